// ===== hdl/lpe_pkg.sv =====
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared types and constants for the log potential evaluator.
// ----------------------------------------------------------------------------
package lpe_pkg;

  // Pipeline depth of the restoring divider (one quotient bit per stage)
  localparam int DIV_STEPS = 64;
  // Pipeline depth of the log2 unit (one fraction bit per stage)
  localparam int LOG_STEPS = 32;

  // ln(2) in Q0.32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // Operation codes
  localparam logic [1:0] OP_VALUE = 2'd0;
  localparam logic [1:0] OP_D1    = 2'd1;
  localparam logic [1:0] OP_D2    = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NEG_X  = 2'd1,
    ST_ZERO_X = 2'd2,
    ST_SAT    = 2'd3
  } stat_t;

  // Control group that travels with every item
  typedef struct packed {
    logic [1:0] op;
    logic       special;  // result forced to zero with stat
    logic       ovf;      // derivative quotient known to be >= 2^32
    stat_t      stat;
    logic       rneg;     // sign of the final result
    logic       dxneg;    // sign of x - 1 (value op)
  } ctl_t;

  // Sideband through the divider
  typedef struct packed {
    ctl_t        ctl;
    logic [4:0]  pos;
    logic [30:0] mant;
  } div_side_t;

  // Sideband through the log unit
  typedef struct packed {
    ctl_t        ctl;
    logic [4:0]  pos;
    logic [63:0] quo;
  } log_side_t;

endpackage

// ===== hdl/lpe_if.sv =====
// ----------------------------------------------------------------------------
// lpe_in_if / lpe_out_if
// Valid/ready channels for samples and results.
// ----------------------------------------------------------------------------
interface lpe_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] x_value;

  modport source (output valid, op, x_value, input ready);
  modport sink   (input valid, op, x_value, output ready);
endinterface

interface lpe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

// ===== hdl/lpe_div.sv =====
// ----------------------------------------------------------------------------
// lpe_div
// Pipelined restoring divider: 128-bit dividend by 96-bit divisor, 64-bit
// quotient, one quotient bit per stage. The dividend's upper 64 bits must be
// below the divisor.
// ----------------------------------------------------------------------------
module lpe_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [127:0]        in_num,
  input  logic [95:0]         in_den,
  input  lpe_pkg::div_side_t  in_side,
  output logic                out_valid,
  output logic [63:0]         out_quo,
  output lpe_pkg::div_side_t  out_side
);
  import lpe_pkg::*;

  logic        v_r    [1:DIV_STEPS];
  logic [95:0] rem_r  [1:DIV_STEPS];
  logic [63:0] low_r  [1:DIV_STEPS];
  logic [63:0] quo_r  [1:DIV_STEPS];
  logic [95:0] den_r  [1:DIV_STEPS];
  div_side_t   side_r [1:DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic        v_i;
    logic [95:0] rem_i;
    logic [63:0] low_i;
    logic [63:0] quo_i;
    logic [95:0] den_i;
    div_side_t   side_i;
    logic [96:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = {32'b0, in_num[127:64]};
      assign low_i  = in_num[63:0];
      assign quo_i  = '0;
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[k];
      assign rem_i  = rem_r[k];
      assign low_i  = low_r[k];
      assign quo_i  = quo_r[k];
      assign den_i  = den_r[k];
      assign side_i = side_r[k];
    end

    // shift in next dividend bit, subtract when it fits
    assign trial = {rem_i, low_i[63]};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1]  <= ge ? 96'(trial - {1'b0, den_i}) : trial[95:0];
        low_r[k+1]  <= {low_i[62:0], 1'b0};
        quo_r[k+1]  <= {quo_i[62:0], ge};
        den_r[k+1]  <= den_i;
        side_r[k+1] <= side_i;
      end
    end
  end

  assign out_valid = v_r[DIV_STEPS];
  assign out_quo   = quo_r[DIV_STEPS];
  assign out_side  = side_r[DIV_STEPS];

endmodule

// ===== hdl/lpe_log.sv =====
// ----------------------------------------------------------------------------
// lpe_log
// Pipelined log2 fraction: squares a Q1.30 mantissa once per stage and
// emits one fraction bit per stage.
// ----------------------------------------------------------------------------
module lpe_log (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [30:0]         in_mant,
  input  lpe_pkg::log_side_t  in_side,
  output logic                out_valid,
  output logic [31:0]         out_frac,
  output lpe_pkg::log_side_t  out_side
);
  import lpe_pkg::*;

  logic        v_r    [1:LOG_STEPS];
  logic [30:0] mant_r [1:LOG_STEPS];
  logic [31:0] frac_r [1:LOG_STEPS];
  log_side_t   side_r [1:LOG_STEPS];

  for (genvar k = 0; k < LOG_STEPS; k++) begin : g_step
    logic        v_i;
    logic [30:0] mant_i;
    logic [31:0] frac_i;
    log_side_t   side_i;
    logic [61:0] sq;
    logic [31:0] sq_q30;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign mant_i = in_mant;
      assign frac_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[k];
      assign mant_i = mant_r[k];
      assign frac_i = frac_r[k];
      assign side_i = side_r[k];
    end

    // square in Q1.30; a square of 2.0 or more is halved and yields a 1
    assign sq     = {31'b0, mant_i} * {31'b0, mant_i};
    assign sq_q30 = sq[61:30];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mant_r[k+1] <= sq_q30[31] ? sq_q30[31:1] : sq_q30[30:0];
        frac_r[k+1] <= {frac_i[30:0], sq_q30[31]};
        side_r[k+1] <= side_i;
      end
    end
  end

  assign out_valid = v_r[LOG_STEPS];
  assign out_frac  = frac_r[LOG_STEPS];
  assign out_side  = side_r[LOG_STEPS];

endmodule

// ===== hdl/log_potential_eval.sv =====
// ----------------------------------------------------------------------------
// log_potential_eval
// Logarithmic potential A*(ln x - (x-1)/x) and its first two derivatives in
// signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// One sample is taken every clock while the pipeline advances. Six front
// stages feed the 64-stage divider (one quotient bit per stage) and the
// 32-stage log2 unit (one squaring per stage), followed by six back stages
// and the output register. The whole pipeline holds only while its last
// stage is full and the output register is still waiting; otherwise bubbles
// close up. scale_a is written through cfg_we/cfg_wdata and must only change
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module log_potential_eval #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  lpe_in_if.sink             in_if,
  lpe_out_if.source          out_if,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);
  import lpe_pkg::*;

  localparam logic [33:0] ONE_Q = 34'(64'd1 << FRAC_BITS);
  localparam logic [33:0] TWO_Q = 34'(64'd2 << FRAC_BITS);
  localparam logic [5:0]  FB6   = 6'(FRAC_BITS);
  localparam logic [64:0] LIM_P = 65'h0_7FFF_FFFF;
  localparam logic [64:0] LIM_N = 65'h0_8000_0000;

  // configuration
  logic [31:0] scale_a_r;
  logic [31:0] amag;
  logic        aneg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_a_r <= 32'(64'd1 << FRAC_BITS);
    end else if (cfg_we) begin
      scale_a_r <= cfg_wdata;
    end
  end

  assign aneg = scale_a_r[31];
  assign amag = aneg ? (32'd0 - scale_a_r) : scale_a_r;

  // global advance: hold only when the last stage cannot drain
  logic adv;
  logic n_v_r;
  logic out_v_r;

  assign adv         = !(n_v_r && out_v_r && !out_if.ready);
  assign in_if.ready = adv;

  // --------------------------------------------------------------------------
  // Stage A: input beat
  logic        a_v_r;
  logic [1:0]  a_op_r;
  logic [31:0] a_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (adv) a_v_r <= in_if.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op_r <= in_if.op;
      a_x_r  <= in_if.x_value;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: classify, magnitudes, msb position and mantissa
  logic [33:0] dx_nxt;
  logic [33:0] dxn_nxt;
  logic [32:0] dxmag_nxt;
  logic [31:0] xmag_nxt;
  logic [4:0]  pos_nxt;
  logic [30:0] mant_nxt;
  logic        op_known;
  ctl_t        b_ctl_nxt;

  assign dx_nxt    = (a_op_r == OP_D2) ? (TWO_Q - {{2{a_x_r[31]}}, a_x_r})
                                       : ({{2{a_x_r[31]}}, a_x_r} - ONE_Q);
  assign dxn_nxt   = 34'd0 - dx_nxt;
  assign dxmag_nxt = dx_nxt[33] ? dxn_nxt[32:0] : dx_nxt[32:0];
  assign xmag_nxt  = a_x_r[31] ? (32'd0 - a_x_r) : a_x_r;
  assign op_known  = a_op_r inside {OP_VALUE, OP_D1, OP_D2};

  // msb search over the positive range
  always_comb begin
    pos_nxt = '0;
    for (int i = 0; i < 31; i++) begin
      if (a_x_r[i]) pos_nxt = 5'(i);
    end
  end

  assign mant_nxt = a_x_r[30:0] << (5'd30 - pos_nxt);

  always_comb begin
    b_ctl_nxt       = '0;
    b_ctl_nxt.op    = a_op_r;
    b_ctl_nxt.stat  = ST_OK;
    b_ctl_nxt.dxneg = dx_nxt[33];
    b_ctl_nxt.rneg  = aneg ^ dx_nxt[33] ^ ((a_op_r == OP_D2) && a_x_r[31]);
    if ((a_op_r == OP_VALUE) && a_x_r[31]) begin
      b_ctl_nxt.special = 1'b1;
      b_ctl_nxt.stat    = ST_NEG_X;
    end else if (op_known && (a_x_r == 32'd0)) begin
      b_ctl_nxt.special = 1'b1;
      b_ctl_nxt.stat    = ST_ZERO_X;
    end else if (!op_known) begin
      b_ctl_nxt.special = 1'b1;
    end
  end

  logic        b_v_r;
  ctl_t        b_ctl_r;
  logic [32:0] b_dxmag_r;
  logic [31:0] b_xmag_r;
  logic [4:0]  b_pos_r;
  logic [30:0] b_mant_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (adv) b_v_r <= a_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ctl_r   <= b_ctl_nxt;
      b_dxmag_r <= dxmag_nxt;
      b_xmag_r  <= xmag_nxt;
      b_pos_r   <= pos_nxt;
      b_mant_r  <= mant_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: |a|*|dx|, x^2, value-op dividend
  logic        c_v_r;
  ctl_t        c_ctl_r;
  logic [64:0] c_nprod_r;
  logic [63:0] c_x2_r;
  logic [63:0] c_n0_r;
  logic [31:0] c_xmag_r;
  logic [4:0]  c_pos_r;
  logic [30:0] c_mant_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (adv) c_v_r <= b_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_ctl_r   <= b_ctl_r;
      c_nprod_r <= {33'b0, amag} * {32'b0, b_dxmag_r};
      c_x2_r    <= {32'b0, b_xmag_r} * {32'b0, b_xmag_r};
      c_n0_r    <= {b_dxmag_r[31:0], 32'b0};
      c_xmag_r  <= b_xmag_r;
      c_pos_r   <= b_pos_r;
      c_mant_r  <= b_mant_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: x^3 partial products, scaled dividend
  logic [127:0] nprod_ext;
  logic [127:0] d_num_nxt;

  assign nprod_ext = {63'b0, c_nprod_r};

  always_comb begin
    case (c_ctl_r.op)
      OP_VALUE: d_num_nxt = {64'b0, c_n0_r};
      OP_D1:    d_num_nxt = nprod_ext << FRAC_BITS;
      OP_D2:    d_num_nxt = nprod_ext << (2 * FRAC_BITS);
      default:  d_num_nxt = '0;
    endcase
  end

  logic         d_v_r;
  ctl_t         d_ctl_r;
  logic [127:0] d_num_r;
  logic [63:0]  d_pplo_r;
  logic [63:0]  d_pphi_r;
  logic [63:0]  d_x2_r;
  logic [31:0]  d_xmag_r;
  logic [4:0]   d_pos_r;
  logic [30:0]  d_mant_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (adv) d_v_r <= c_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_ctl_r  <= c_ctl_r;
      d_num_r  <= d_num_nxt;
      d_pplo_r <= {32'b0, c_x2_r[31:0]} * {32'b0, c_xmag_r};
      d_pphi_r <= {32'b0, c_x2_r[63:32]} * {32'b0, c_xmag_r};
      d_x2_r   <= c_x2_r;
      d_xmag_r <= c_xmag_r;
      d_pos_r  <= c_pos_r;
      d_mant_r <= c_mant_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: divisor per op
  logic [95:0] e_den_nxt;

  always_comb begin
    case (d_ctl_r.op)
      OP_VALUE: e_den_nxt = {64'b0, d_xmag_r};
      OP_D1:    e_den_nxt = {32'b0, d_x2_r};
      OP_D2:    e_den_nxt = {32'b0, d_pplo_r} + {d_pphi_r, 32'b0};
      default:  e_den_nxt = 96'd1;
    endcase
  end

  logic         e_v_r;
  ctl_t         e_ctl_r;
  logic [127:0] e_num_r;
  logic [95:0]  e_den_r;
  logic [4:0]   e_pos_r;
  logic [30:0]  e_mant_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else if (adv) e_v_r <= d_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_ctl_r  <= d_ctl_r;
      e_num_r  <= d_num_r;
      e_den_r  <= e_den_nxt;
      e_pos_r  <= d_pos_r;
      e_mant_r <= d_mant_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: derivative overflow check (quotient >= 2^32)
  logic      ovf_nxt;
  div_side_t f_side_nxt;

  assign ovf_nxt = ((e_ctl_r.op == OP_D1) || (e_ctl_r.op == OP_D2)) && !e_ctl_r.special
                   && (e_num_r >= {e_den_r, 32'b0});

  always_comb begin
    f_side_nxt         = '0;
    f_side_nxt.ctl     = e_ctl_r;
    f_side_nxt.ctl.ovf = ovf_nxt;
    f_side_nxt.pos     = e_pos_r;
    f_side_nxt.mant    = e_mant_r;
  end

  logic         f_v_r;
  logic [127:0] f_num_r;
  logic [95:0]  f_den_r;
  div_side_t    f_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) f_v_r <= 1'b0;
    else if (adv) f_v_r <= e_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_num_r  <= (e_ctl_r.special || ovf_nxt) ? '0 : e_num_r;
      f_den_r  <= e_den_r;
      f_side_r <= f_side_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Divider
  logic        dv_v;
  logic [63:0] dv_quo;
  div_side_t   dv_side;

  lpe_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f_v_r),
    .in_num    (f_num_r),
    .in_den    (f_den_r),
    .in_side   (f_side_r),
    .out_valid (dv_v),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // --------------------------------------------------------------------------
  // Log2 fraction
  log_side_t lg_in_side;
  logic      lg_v;
  logic [31:0] lg_frac;
  log_side_t lg_side;

  always_comb begin
    lg_in_side     = '0;
    lg_in_side.ctl = dv_side.ctl;
    lg_in_side.pos = dv_side.pos;
    lg_in_side.quo = dv_quo;
  end

  lpe_log u_log (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (dv_v),
    .in_mant   (dv_side.mant),
    .in_side   (lg_in_side),
    .out_valid (lg_v),
    .out_frac  (lg_frac),
    .out_side  (lg_side)
  );

  // --------------------------------------------------------------------------
  // Stage I: |log2 x| in Q.32 and its sign
  logic [5:0]  pos6;
  logic [37:0] l2mag_nxt;
  logic        l2neg_nxt;

  assign pos6 = {1'b0, lg_side.pos};

  always_comb begin
    if (pos6 >= FB6) begin
      l2neg_nxt = 1'b0;
      l2mag_nxt = {pos6 - FB6, lg_frac};
    end else begin
      l2neg_nxt = 1'b1;
      l2mag_nxt = {FB6 - pos6, 32'b0} - {6'b0, lg_frac};
    end
  end

  logic        i_v_r;
  ctl_t        i_ctl_r;
  logic [63:0] i_quo_r;
  logic [37:0] i_l2mag_r;
  logic        i_l2neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) i_v_r <= 1'b0;
    else if (adv) i_v_r <= lg_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_ctl_r   <= lg_side.ctl;
      i_quo_r   <= lg_side.quo;
      i_l2mag_r <= l2mag_nxt;
      i_l2neg_r <= l2neg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage J: |log2 x| * ln2 partial products, signed (x-1)/x
  logic        j_v_r;
  ctl_t        j_ctl_r;
  logic [63:0] j_quo_r;
  logic [63:0] j_qs_r;
  logic [63:0] j_pl_r;
  logic [37:0] j_ph_r;
  logic        j_l2neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) j_v_r <= 1'b0;
    else if (adv) j_v_r <= i_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_ctl_r   <= i_ctl_r;
      j_quo_r   <= i_quo_r;
      j_qs_r    <= i_ctl_r.dxneg ? (64'd0 - i_quo_r) : i_quo_r;
      j_pl_r    <= {32'b0, i_l2mag_r[31:0]} * {32'b0, LN2_Q32};
      j_ph_r    <= {32'b0, i_l2mag_r[37:32]} * {6'b0, LN2_Q32};
      j_l2neg_r <= i_l2neg_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage K: y = ln x - (x-1)/x in Q.32
  logic [38:0] lm_nxt;
  logic [63:0] ln_nxt;

  assign lm_nxt = {7'b0, j_pl_r[63:32]} + {1'b0, j_ph_r};
  assign ln_nxt = j_l2neg_r ? (64'd0 - {25'b0, lm_nxt}) : {25'b0, lm_nxt};

  logic        k_v_r;
  ctl_t        k_ctl_r;
  logic [63:0] k_quo_r;
  logic [63:0] k_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) k_v_r <= 1'b0;
    else if (adv) k_v_r <= j_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_ctl_r <= j_ctl_r;
      k_quo_r <= j_quo_r;
      k_y_r   <= ln_nxt - j_qs_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage L: |y| and value-op result sign
  ctl_t l_ctl_nxt;

  always_comb begin
    l_ctl_nxt = k_ctl_r;
    if (k_ctl_r.op == OP_VALUE) l_ctl_nxt.rneg = aneg ^ k_y_r[63];
  end

  logic        l_v_r;
  ctl_t        l_ctl_r;
  logic [63:0] l_quo_r;
  logic [63:0] l_ymag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) l_v_r <= 1'b0;
    else if (adv) l_v_r <= k_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_ctl_r  <= l_ctl_nxt;
      l_quo_r  <= k_quo_r;
      l_ymag_r <= k_y_r[63] ? (64'd0 - k_y_r) : k_y_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage M: |a|*|y| partial products
  logic        m_v_r;
  ctl_t        m_ctl_r;
  logic [63:0] m_quo_r;
  logic [63:0] m_palo_r;
  logic [63:0] m_pahi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else if (adv) m_v_r <= l_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_ctl_r  <= l_ctl_r;
      m_quo_r  <= l_quo_r;
      m_palo_r <= {32'b0, amag} * {32'b0, l_ymag_r[31:0]};
      m_pahi_r <= {32'b0, amag} * {32'b0, l_ymag_r[63:32]};
    end
  end

  // --------------------------------------------------------------------------
  // Stage N: magnitude, saturation and result select
  logic [64:0] mag_nxt;
  logic [64:0] lim_nxt;
  logic        sat_nxt;
  logic [31:0] rmag_nxt;
  logic [31:0] n_res_nxt;
  stat_t       n_stat_nxt;

  assign mag_nxt = {33'b0, m_palo_r[63:32]} + {1'b0, m_pahi_r};
  assign lim_nxt = m_ctl_r.rneg ? LIM_N : LIM_P;

  always_comb begin
    if (m_ctl_r.op == OP_VALUE) begin
      sat_nxt  = mag_nxt > lim_nxt;
      rmag_nxt = mag_nxt[31:0];
    end else begin
      sat_nxt  = m_ctl_r.ovf || ({1'b0, m_quo_r} > lim_nxt);
      rmag_nxt = m_quo_r[31:0];
    end

    if (m_ctl_r.special) begin
      n_res_nxt  = '0;
      n_stat_nxt = m_ctl_r.stat;
    end else if (sat_nxt) begin
      n_res_nxt  = m_ctl_r.rneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      n_stat_nxt = ST_SAT;
    end else begin
      n_res_nxt  = m_ctl_r.rneg ? (32'd0 - rmag_nxt) : rmag_nxt;
      n_stat_nxt = ST_OK;
    end
  end

  logic [31:0] n_res_r;
  stat_t       n_stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) n_v_r <= 1'b0;
    else if (adv) n_v_r <= m_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_res_r  <= n_res_nxt;
      n_stat_r <= n_stat_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  logic        out_load;
  logic [31:0] out_res_r;
  stat_t       out_stat_r;

  assign out_load = !out_v_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (out_load) out_v_r <= n_v_r;
  end

  always_ff @(posedge clk) begin
    if (out_load && n_v_r) begin
      out_res_r  <= n_res_r;
      out_stat_r <= n_stat_r;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.result_value = out_res_r;
  assign out_if.status       = out_stat_r;

endmodule

// ===== hdl/lpe_chk.sv =====
// ----------------------------------------------------------------------------
// lpe_chk
// Port-level checks for log_potential_eval, attached by bind.
// ----------------------------------------------------------------------------
module lpe_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result,
  input logic [1:0]  out_status
);
  import lpe_pkg::*;

  // a waiting result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_status))
    else $error("result beat changed while stalled");

  // empty output never blocks the input
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // saturated results sit at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_SAT) |->
      (out_result == 32'h7FFF_FFFF) || (out_result == 32'h8000_0000))
    else $error("saturated result off rail");

  // domain errors give zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_NEG_X) || (out_status == ST_ZERO_X)) |->
      (out_result == 32'd0))
    else $error("domain error with nonzero result");

  // the input is held off only behind a stalled result beat
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without pending result (valid %0b)", in_valid);

endmodule

bind log_potential_eval lpe_chk u_lpe_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_result (out_if.result_value),
  .out_status (out_if.status)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for log_potential_eval. A sample driver and a result
// monitor run on the valid/ready channels with random idle bursts on both
// sides. Every accepted sample is evaluated by a bit-true fixed point
// model of the potential and its derivatives, and the result is queued for
// in-order comparison. The scale register is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
  import lpe_pkg::*;

  localparam int                 FRAC      = 16;
  localparam longint             ONE_FX    = 64'sd1 << FRAC;
  localparam logic [1:0]         OP_UNUSED = 2'd3;
  localparam logic signed [31:0] A_RESET   = 32'sd65536;
  localparam int                 PIPE_LAT  = 109;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] x;
  } sample_t;

  typedef struct {
    logic signed [31:0] value;
    stat_t              status;
  } potential_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [31:0] cfg_wdata;

  lpe_in_if  in_ch ();
  lpe_out_if out_ch ();

  log_potential_eval #(.FRAC_BITS(FRAC)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  sample_t            pending_samples[$];
  potential_t         expected_results[$];
  logic signed [31:0] scale_copy;
  int                 fail_count = 0;
  bit                 quiet;
  bit                 took;
  int                 send_gap;
  int                 recv_gap;
  int                 hold_cnt;
  int                 stall_token;
  int                 stall_seen;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Magnitude of a signed 64-bit value
  function automatic logic [63:0] mag_of(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // Clamp a sign-magnitude value to 32 bits
  function automatic potential_t clamp32(bit neg, logic [127:0] mag);
    potential_t r;
    logic [127:0] limit;
    limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (mag > limit) begin
      r.value  = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      r.status = ST_SAT;
    end else begin
      r.value  = neg ? -mag[31:0] : mag[31:0];
      r.status = ST_OK;
    end
    return r;
  endfunction

  // Bit-true evaluation of one sample against scale a
  function automatic potential_t eval_potential(logic [1:0] op, logic signed [31:0] x,
                                                logic signed [31:0] a);
    potential_t r;
    longint sx, sa, dx, q, l2, lnv, y;
    logic [63:0] ux, qm, m, frac, lm;
    logic [127:0] num, den, mag, prod;
    int p;
    bit neg;
    sx = x;
    sa = a;
    ux = 64'(sx);
    r.value = '0;
    r.status = ST_OK;
    if (op == OP_VALUE && sx < 0) begin
      r.status = ST_NEG_X;
    end else if (op != OP_UNUSED && sx == 0) begin
      r.status = ST_ZERO_X;
    end else if (op == OP_VALUE) begin
      dx = sx - ONE_FX;
      qm = (mag_of(dx) << 32) / ux;
      q = dx < 0 ? -longint'(qm) : longint'(qm);
      // log2 by repeated squaring of the Q1.30 mantissa
      p = 30;
      while (p > 0 && !ux[p]) p--;
      m = ux << (30 - p);
      frac = '0;
      for (int i = 0; i < 32; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= 64'h8000_0000) begin
          m = m >> 1;
          frac[0] = 1'b1;
        end
      end
      l2 = longint'(p - FRAC) * 64'sd4294967296 + longint'(frac);
      prod = 128'(mag_of(l2)) * 128'(LN2_Q32);
      lm = prod[95:32];
      lnv = l2 < 0 ? -longint'(lm) : longint'(lm);
      y = lnv - q;
      prod = 128'(mag_of(sa)) * 128'(mag_of(y));
      neg = (sa < 0) != (y < 0);
      r = clamp32(neg, prod >> 32);
    end else if (op == OP_D1) begin
      dx = sx - ONE_FX;
      num = 128'(mag_of(sa)) * 128'(mag_of(dx)) * 128'(ONE_FX);
      den = 128'(mag_of(sx)) * 128'(mag_of(sx));
      mag = num / den;
      neg = (sa < 0) != (dx < 0);
      r = clamp32(neg, mag);
    end else if (op == OP_D2) begin
      dx = 2 * ONE_FX - sx;
      num = 128'(mag_of(sa)) * 128'(mag_of(dx)) * 128'(ONE_FX) * 128'(ONE_FX);
      den = 128'(mag_of(sx)) * 128'(mag_of(sx)) * 128'(mag_of(sx));
      mag = num / den;
      neg = ((sa < 0) != (dx < 0)) != (sx < 0);
      r = clamp32(neg, mag);
    end
    return r;
  endfunction

  // Sample driver: changes on the falling edge, holds a beat until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.op      <= '0;
      in_ch.x_value <= '0;
      send_gap      <= 0;
    end else if (in_ch.valid && !took) begin
      in_ch.valid <= 1'b1;
    end else if (send_gap > 0) begin
      in_ch.valid <= 1'b0;
      send_gap    <= send_gap - 1;
    end else if (pending_samples.size() > 0) begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        in_ch.valid <= 1'b0;
        send_gap    <= $urandom_range(0, 3);
      end else begin
        in_ch.valid   <= 1'b1;
        in_ch.op      <= pending_samples[0].op;
        in_ch.x_value <= pending_samples[0].x;
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Accepted samples: predict and queue
  always @(posedge clk) begin
    took <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_results.push_back(eval_potential(in_ch.op, in_ch.x_value, scale_copy));
      void'(pending_samples.pop_front());
    end
  end

  // Result ready: random bursts, plus a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= 0;
      hold_cnt     <= 0;
      stall_seen   <= 0;
    end else if (stall_token != stall_seen) begin
      stall_seen   <= stall_token;
      hold_cnt     <= 300;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt     <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap     <= recv_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_gap     <= $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    potential_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: value %0d status %0d",
               out_ch.result_value, out_ch.status);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.result_value !== want.value) begin
          $error("result_value: expected %0d, got %0d", want.value, out_ch.result_value);
          fail_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_x();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(1, 8 * 65536);
      2: return $urandom_range(1, 32'h7FFF_FFFF);
      3: return 32'(-$signed({1'b0, $urandom_range(1, 32'h7FFF_FFFF)}));
      4: return $urandom_range(1, 255);
      default: return ($urandom_range(0, 3) == 0) ? 32'sd0 : $urandom_range(32768, 196608);
    endcase
  endfunction

  function automatic logic [1:0] rand_op();
    return ($urandom_range(0, 15) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
  endfunction

  task automatic queue_sample(logic [1:0] op, logic signed [31:0] x);
    sample_t s;
    s.op = op;
    s.x  = x;
    pending_samples.push_back(s);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) queue_sample(rand_op(), rand_x());
  endtask

  // Wait for an empty pipeline, then write the scale register
  task automatic write_scale(logic signed [31:0] v);
    wait (pending_samples.size() == 0 && expected_results.size() == 0);
    repeat (4) @(negedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= v;
    scale_copy = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus sequence
  initial begin
    logic signed [31:0] edge_x[8];
    logic signed [31:0] scales[10];
    edge_x = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1, 32'sd1,
               32'sd65536, 32'sd131072, 32'sd65535};
    scales = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd65536, 32'sd196608,
               32'sd1, -32'sd1, 32'sd0, 32'sd0, 32'sd0};
    for (int i = 7; i < 10; i++) scales[i] = $urandom();
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    scale_copy  = A_RESET;
    quiet       = 1'b0;
    stall_token = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes in every op at the reset scale
    foreach (edge_x[i]) begin
      queue_sample(OP_VALUE, edge_x[i]);
      queue_sample(OP_D1, edge_x[i]);
      queue_sample(OP_D2, edge_x[i]);
    end
    queue_sample(OP_UNUSED, 32'sd65536);

    // Random phases over a range of scales
    foreach (scales[k]) begin
      write_scale(scales[k]);
      if (k == 9) quiet = 1'b1;
      queue_random(155);
      if (k == 3) begin
        repeat (20) @(negedge clk);
        stall_token = stall_token + 1;
      end
    end

    wait (pending_samples.size() == 0 && expected_results.size() == 0);
    repeat (PIPE_LAT + 20) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lpe_pkg.sv
hdl/lpe_if.sv
hdl/lpe_div.sv
hdl/lpe_log.sv
hdl/log_potential_eval.sv
hdl/lpe_chk.sv
test/testbench.sv
